/* rtl/bjef_pkg.sv */
package bjef_pkg;

  // Decoder phase codes.
  localparam logic [2:0] PH_OPCODE  = 3'd0;
  localparam logic [2:0] PH_OPERAND = 3'd1;
  localparam logic [2:0] PH_JLOW    = 3'd2;
  localparam logic [2:0] PH_JHIGH   = 3'd3;
  localparam logic [2:0] PH_SKIP    = 3'd4;

  // Stream status codes, reported on the final beat.
  localparam logic [1:0] ST_OK            = 2'd0;
  localparam logic [1:0] ST_TRUNC_JUMP    = 2'd1;
  localparam logic [1:0] ST_TARGET_RANGE  = 2'd2;
  localparam logic [1:0] ST_TRUNC_OPERAND = 2'd3;

  // Opcodes.
  localparam logic [7:0] OP_JMP       = 8'h30;
  localparam logic [7:0] OP_PUSH8     = 8'h01;
  localparam logic [7:0] OP_PUSH16    = 8'h02;
  localparam logic [7:0] OP_PUSH32    = 8'h03;
  localparam logic [7:0] OP_PUSH64    = 8'h04;
  localparam logic [7:0] OP_JCC_FIRST = 8'h31;
  localparam logic [7:0] OP_JCC_LAST  = 8'h36;
  localparam logic [7:0] OP_CALL      = 8'h40;
  localparam logic [7:0] OP_IMM_A     = 8'h50;
  localparam logic [7:0] OP_IMM_B     = 8'h60;

  // Number of operand bytes that follow an opcode.
  function automatic logic [3:0] operand_length(input logic [7:0] op);
    logic [3:0] n;
    n = 4'd0;
    if (op == OP_PUSH8 || op == OP_IMM_A || op == OP_IMM_B) begin
      n = 4'd1;
    end else if (op == OP_PUSH16 || op == OP_CALL ||
                 (op >= OP_JCC_FIRST && op <= OP_JCC_LAST)) begin
      n = 4'd2;
    end else if (op == OP_PUSH32) begin
      n = 4'd4;
    end else if (op == OP_PUSH64) begin
      n = 4'd8;
    end
    return n;
  endfunction

endpackage

/* rtl/bytecode_jump_elision_filter.sv */
// Bytecode jump elision filter.
//
// The slave channel takes one bytecode byte per beat in s_axis_tdata, with
// s_axis_tlast marking the last byte of a program. Each opcode is decoded for
// its operand length and copied to the master channel together with its
// operands. An unconditional jump and its 16-bit little-endian forward offset
// are dropped, and so are the bytes it jumps over.
// The master channel carries one beat per kept byte and one on the final
// input byte. m_axis_tuser says whether m_axis_tdata[7:0] holds a kept byte,
// m_axis_tlast marks the final beat and m_axis_tdata[9:8] gives the status
// there: 0 ok, 1 truncated jump, 2 jump target at or past the end,
// 3 truncated operand. On a nonzero status the program's output is unusable.
// A beat passes an input register and then a result register, which offers
// it to the master channel. One byte is taken every cycle while the receiver
// keeps up; the decode between the two registers is combinational. When the
// receiver stalls, the result register holds, and s_axis_tready drops once
// the input register holds a beat as well.
// Reset empties both registers and returns the decoder to expect an opcode;
// the decoder returns there by itself after every final byte.
module bytecode_jump_elision_filter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] code_byte
  input  logic        s_axis_tlast,  // final_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [7:0] out_byte, [9:8] status, [15:10] zero
  output logic        m_axis_tuser,  // byte_valid
  output logic        m_axis_tlast   // stream_done
);

  // Input register.
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  // Decoder state.
  logic [2:0]  phase, phase_next;
  logic [3:0]  operand_left, operand_left_next;
  logic [7:0]  offset_low, offset_low_next;
  logic [15:0] skip_left, skip_left_next;

  // Result register.
  logic       res_valid;
  logic [7:0] res_byte;
  logic       res_kept;
  logic       res_done;
  logic [1:0] res_status;

  logic       advance;
  logic [7:0] ob;
  logic       kept;
  logic [1:0] st;
  logic [3:0] op_len;
  logic [15:0] offset_full;
  logic [15:0] skip_dec;

  // The input register moves on when the result register is free or drains.
  assign advance       = in_valid && (!res_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  assign op_len      = bjef_pkg::operand_length(in_byte);
  assign offset_full = {in_byte, offset_low};
  assign skip_dec    = skip_left - 16'd1;

  always_comb begin
    ob                = 8'd0;
    kept              = 1'b0;
    st                = bjef_pkg::ST_OK;
    phase_next        = phase;
    operand_left_next = operand_left;
    offset_low_next   = offset_low;
    skip_left_next    = skip_left;
    case (phase)
      bjef_pkg::PH_OPERAND: begin
        ob   = in_byte;
        kept = 1'b1;
        if (operand_left <= 4'd1) begin
          operand_left_next = 4'd0;
          phase_next        = bjef_pkg::PH_OPCODE;
        end else begin
          operand_left_next = operand_left - 4'd1;
          if (in_last) st = bjef_pkg::ST_TRUNC_OPERAND;
        end
      end
      bjef_pkg::PH_JLOW: begin
        offset_low_next = in_byte;
        phase_next      = bjef_pkg::PH_JHIGH;
        if (in_last) st = bjef_pkg::ST_TRUNC_JUMP;
      end
      bjef_pkg::PH_JHIGH: begin
        skip_left_next = offset_full;
        phase_next     = (offset_full != 16'd0) ? bjef_pkg::PH_SKIP : bjef_pkg::PH_OPCODE;
        if (in_last) st = bjef_pkg::ST_TARGET_RANGE;
      end
      bjef_pkg::PH_SKIP: begin
        skip_left_next = skip_dec;
        if (skip_dec == 16'd0) phase_next = bjef_pkg::PH_OPCODE;
        if (in_last) st = bjef_pkg::ST_TARGET_RANGE;
      end
      default: begin
        // Expect an opcode; unused phase codes land here as well.
        if (in_byte == bjef_pkg::OP_JMP) begin
          phase_next = bjef_pkg::PH_JLOW;
          if (in_last) st = bjef_pkg::ST_TRUNC_JUMP;
        end else begin
          ob   = in_byte;
          kept = 1'b1;
          if (op_len != 4'd0) begin
            operand_left_next = op_len;
            phase_next        = bjef_pkg::PH_OPERAND;
            if (in_last) st = bjef_pkg::ST_TRUNC_OPERAND;
          end else begin
            phase_next = bjef_pkg::PH_OPCODE;
          end
        end
      end
    endcase
    // The final byte returns the decoder to its starting state.
    if (in_last) begin
      phase_next        = bjef_pkg::PH_OPCODE;
      operand_left_next = 4'd0;
      offset_low_next   = 8'd0;
      skip_left_next    = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid     <= 1'b0;
      res_valid    <= 1'b0;
      phase        <= bjef_pkg::PH_OPCODE;
      operand_left <= 4'd0;
      offset_low   <= 8'd0;
      skip_left    <= 16'd0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (advance) begin
        phase        <= phase_next;
        operand_left <= operand_left_next;
        offset_low   <= offset_low_next;
        skip_left    <= skip_left_next;
        // Dropped bytes produce no beat unless they are final.
        res_valid    <= kept || in_last;
      end else if (m_axis_tready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
    if (advance) begin
      res_byte   <= ob;
      res_kept   <= kept;
      res_done   <= in_last;
      res_status <= st;
    end
  end

  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = {6'd0, res_status, res_byte};
  assign m_axis_tuser  = res_kept;
  assign m_axis_tlast  = res_done;

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps

// Testbench for the bytecode jump elision filter.
//
// An initial block builds bytecode programs: first a few short directed
// ones for the error endings and a clean one, then one program with a long
// jump, then random programs. Most random programs are well formed with
// random operand and skipped bytes; the rest are cut short at a random byte
// or are plain noise. Every byte goes into a queue that feeds the
// slave-side driver. The driver decodes each accepted beat with its own
// copy of the decoder and queues the beat that the master side should
// produce for it. The monitor compares each master beat field by field
// with the oldest queued beat.
module tb_top;

  // One byte waiting to be offered, with the idle cycles that precede it.
  typedef struct {
    logic [7:0]  code;
    logic        fin;
    int unsigned gap;
  } code_beat_t;

  // One master beat as the decoder should produce it.
  typedef struct packed {
    logic [7:0] data;
    logic       kept;
    logic       done;
    logic [1:0] status;
  } filt_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;  // [7:0] code_byte
  logic        s_axis_tlast = 1'b0;   // final_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;          // [7:0] out_byte, [9:8] status, [15:10] zero
  logic        m_axis_tuser;          // byte_valid
  logic        m_axis_tlast;          // stream_done

  bytecode_jump_elision_filter dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #5 clk = ~clk;

  code_beat_t  code_fifo[$];   // bytes not yet offered
  filt_beat_t  filt_fifo[$];   // master beats still owed by the block
  logic [7:0]  prog[$];        // program under construction
  bit          gap_mode;       // 1: random idle cycles between input bytes
  int unsigned err_count;
  int unsigned gap_wait;
  int unsigned stall_left;
  int unsigned beats_seen;

  // Decoder state mirrored by the testbench.
  logic [2:0]  dec_phase = bjef_pkg::PH_OPCODE;
  logic [3:0]  ops_left = 4'd0;
  logic [7:0]  off_lo = 8'h00;
  logic [15:0] skip_cnt = 16'h0000;

  // Long receiver hold-off, timed in cycles after reset. It starts once the
  // random programs are flowing; the sender keeps offering during it, so both
  // internal registers fill and the input stalls.
  localparam int unsigned HOLD_START = 700;
  localparam int unsigned HOLD_LEN   = 300;
  int unsigned cyc_cnt;
  logic        hold_off = 1'b0;

  task automatic flag_error(input string msg);
    err_count++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  // Operand bytes that follow an opcode.
  function automatic int unsigned operand_bytes(input logic [7:0] op);
    case (op)
      bjef_pkg::OP_PUSH8, bjef_pkg::OP_IMM_A, bjef_pkg::OP_IMM_B: return 1;
      bjef_pkg::OP_PUSH16, bjef_pkg::OP_CALL:                     return 2;
      bjef_pkg::OP_PUSH32:                                        return 4;
      bjef_pkg::OP_PUSH64:                                        return 8;
      default: return (op >= bjef_pkg::OP_JCC_FIRST && op <= bjef_pkg::OP_JCC_LAST) ? 2 : 0;
    endcase
  endfunction

  // Advances the mirrored decoder by one accepted byte and queues the
  // master beat it produces, if any.
  task automatic decode_beat(input logic [7:0] code, input logic fin);
    filt_beat_t r;
    int unsigned n;
    r = '0;
    r.done = fin;
    case (dec_phase)
      bjef_pkg::PH_OPERAND: begin
        r.data = code;
        r.kept = 1'b1;
        if (ops_left <= 4'd1) begin
          ops_left = 4'd0;
          dec_phase = bjef_pkg::PH_OPCODE;
        end else begin
          ops_left = ops_left - 4'd1;
          if (fin) r.status = bjef_pkg::ST_TRUNC_OPERAND;
        end
      end
      bjef_pkg::PH_JLOW: begin
        off_lo = code;
        dec_phase = bjef_pkg::PH_JHIGH;
        if (fin) r.status = bjef_pkg::ST_TRUNC_JUMP;
      end
      bjef_pkg::PH_JHIGH: begin
        skip_cnt = {code, off_lo};
        dec_phase = (skip_cnt != 16'h0000) ? bjef_pkg::PH_SKIP : bjef_pkg::PH_OPCODE;
        if (fin) r.status = bjef_pkg::ST_TARGET_RANGE;
      end
      bjef_pkg::PH_SKIP: begin
        skip_cnt = skip_cnt - 16'h0001;
        if (skip_cnt == 16'h0000) dec_phase = bjef_pkg::PH_OPCODE;
        if (fin) r.status = bjef_pkg::ST_TARGET_RANGE;
      end
      default: begin
        if (code == bjef_pkg::OP_JMP) begin
          dec_phase = bjef_pkg::PH_JLOW;
          if (fin) r.status = bjef_pkg::ST_TRUNC_JUMP;
        end else begin
          n = operand_bytes(code);
          r.data = code;
          r.kept = 1'b1;
          if (n != 0) begin
            ops_left = n[3:0];
            dec_phase = bjef_pkg::PH_OPERAND;
            if (fin) r.status = bjef_pkg::ST_TRUNC_OPERAND;
          end else begin
            dec_phase = bjef_pkg::PH_OPCODE;
          end
        end
      end
    endcase
    if (fin || r.kept) filt_fifo.insert(filt_fifo.size(), r);
    // Every program ends with the decoder back in its reset state.
    if (fin) begin
      dec_phase = bjef_pkg::PH_OPCODE;
      ops_left = 4'd0;
      off_lo = 8'h00;
      skip_cnt = 16'h0000;
    end
  endtask

  // Moves the program under construction into the driver queue, flagging
  // its last byte.
  task automatic push_prog();
    code_beat_t b;
    foreach (prog[i]) begin
      b.code = prog[i];
      b.fin = (i == prog.size() - 1);
      b.gap = gap_mode ? $urandom_range(0, 6) : 0;
      code_fifo.insert(code_fifo.size(), b);
    end
    prog.delete();
  endtask

  function automatic logic [7:0] pick_operand_op();
    case ($urandom_range(0, 8))
      0: return bjef_pkg::OP_PUSH8;
      1: return bjef_pkg::OP_PUSH16;
      2: return bjef_pkg::OP_PUSH32;
      3: return bjef_pkg::OP_PUSH64;
      4: return bjef_pkg::OP_JCC_FIRST + 8'($urandom_range(0, 5));
      5: return bjef_pkg::OP_CALL;
      6: return bjef_pkg::OP_IMM_A;
      7: return bjef_pkg::OP_IMM_B;
      default: return bjef_pkg::OP_JCC_LAST;
    endcase
  endfunction

  // Builds a well-formed program: a chain of instructions in which every
  // jump lands on a later instruction.
  task automatic build_program();
    int unsigned ninsn, off, r, len;
    logic [7:0] op;
    ninsn = $urandom_range(1, 12);
    for (int unsigned k = 0; k < ninsn; k++) begin
      r = $urandom_range(0, 9);
      if (r < 2 && k != ninsn - 1) begin
        off = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 400)
                                           : $urandom_range(0, 6);
        prog = {prog, bjef_pkg::OP_JMP, off[7:0], off[15:8]};
        repeat (off) prog = {prog, 8'($urandom_range(0, 255))};
      end else begin
        if (r < 7) begin
          op = pick_operand_op();
        end else begin
          op = 8'($urandom_range(0, 255));
          if (op == bjef_pkg::OP_JMP) op = 8'hFF;
        end
        len = operand_bytes(op);
        prog = {prog, op};
        repeat (len) prog = {prog, 8'($urandom_range(0, 255))};
      end
    end
  endtask

  // Slave-side driver. The beat on the bus is decoded when it is taken;
  // the next byte goes up after its drawn number of idle cycles.
  always @(posedge clk) begin
    logic nxt_valid;
    code_beat_t b;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      gap_wait = 0;
    end else begin
      nxt_valid = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        decode_beat(s_axis_tdata, s_axis_tlast);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && code_fifo.size() != 0) begin
        if (gap_wait < code_fifo[0].gap) begin
          gap_wait++;
        end else begin
          b = code_fifo.pop_front();
          s_axis_tdata <= b.code;
          s_axis_tlast <= b.fin;
          nxt_valid = 1'b1;
          gap_wait = 0;
        end
      end
      s_axis_tvalid <= nxt_valid;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      cyc_cnt <= 0;
      hold_off <= 1'b0;
    end else begin
      cyc_cnt <= cyc_cnt + 1;
      hold_off <= (cyc_cnt >= HOLD_START) && (cyc_cnt < HOLD_START + HOLD_LEN);
    end
  end

  // Master-side monitor. Stalls are drawn per beat, in stretches of 128
  // beats that alternate between random stalls and none at all.
  always @(posedge clk) begin
    filt_beat_t e;
    logic nxt_ready;
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else begin
      nxt_ready = m_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        if (filt_fifo.size() == 0) begin
          flag_error($sformatf("beat %0d not expected: data %04h user %0b last %0b",
                               beats_seen, m_axis_tdata, m_axis_tuser, m_axis_tlast));
        end else begin
          e = filt_fifo.pop_front();
          if (m_axis_tdata[7:0] !== e.data)
            flag_error($sformatf("beat %0d out_byte %02h, want %02h",
                                 beats_seen, m_axis_tdata[7:0], e.data));
          if (m_axis_tuser !== e.kept)
            flag_error($sformatf("beat %0d byte_valid %b, want %b",
                                 beats_seen, m_axis_tuser, e.kept));
          if (m_axis_tdata[9:8] !== e.status)
            flag_error($sformatf("beat %0d status %0d, want %0d",
                                 beats_seen, m_axis_tdata[9:8], e.status));
          if (m_axis_tlast !== e.done)
            flag_error($sformatf("beat %0d stream_done %b, want %b",
                                 beats_seen, m_axis_tlast, e.done));
        end
        beats_seen++;
        stall_left = beats_seen[7] ? $urandom_range(0, 6) : 0;
        nxt_ready = (stall_left == 0);
      end else if (!m_axis_tready) begin
        if (stall_left != 0) stall_left--;
        nxt_ready = (stall_left == 0);
      end
      if (hold_off) nxt_ready = 1'b0;
      m_axis_tready <= nxt_ready;
    end
  end

  initial begin
    int unsigned cut, nstream, kind;
    nstream = 0;
    gap_mode = 1'b1;

    // Jump opcode as the last byte: truncated jump.
    prog = '{bjef_pkg::OP_JMP};
    push_prog();
    // Last byte is the low offset byte: truncated jump.
    prog = '{bjef_pkg::OP_JMP, 8'h05};
    push_prog();
    // Last byte is the high offset byte, even with offset zero: target
    // out of range.
    prog = '{bjef_pkg::OP_JMP, 8'h00, 8'h00};
    push_prog();
    // Program ends inside an operand.
    prog = '{bjef_pkg::OP_PUSH64, 8'hFF, 8'h00};
    push_prog();
    // Last byte is being skipped by a jump.
    prog = '{bjef_pkg::OP_JMP, 8'h02, 8'h00, 8'h11, 8'h22};
    push_prog();
    // Clean program: plain opcode, operand extremes, a jump over one byte.
    gap_mode = 1'b0;
    prog = '{8'hFF, bjef_pkg::OP_PUSH8, 8'h80, bjef_pkg::OP_JMP, 8'h01, 8'h00, 8'hAB,
             bjef_pkg::OP_IMM_B, 8'h7F, 8'h00};
    push_prog();

    // One long forward jump, offered without gaps, so the skip counter
    // counts down across its low byte boundary.
    prog = '{bjef_pkg::OP_JMP, 8'h05, 8'h01};
    repeat (16'h0105) prog = {prog, 8'($urandom_range(0, 255))};
    prog = {prog, bjef_pkg::OP_IMM_A, 8'h5A};
    push_prog();

    while (code_fifo.size() < 1700) begin
      nstream++;
      gap_mode = nstream[4];
      kind = $urandom_range(0, 19);
      if (kind < 2) begin
        // Noise: random bytes, mostly ending somewhere odd.
        repeat ($urandom_range(1, 20)) prog = {prog, 8'($urandom_range(0, 255))};
      end else begin
        build_program();
        if (kind < 6) begin
          // Broken program: cut at a random byte.
          cut = $urandom_range(1, prog.size());
          prog = prog[0:cut-1];
        end
      end
      push_prog();
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Sample at the falling edge, away from the driver and the monitor.
    @(negedge clk);
    while (code_fifo.size() != 0 || s_axis_tvalid || filt_fifo.size() != 0)
      @(negedge clk);
    // Two register stages in the block; allow a margin for stray beats.
    repeat (20) @(posedge clk);
    if (filt_fifo.size() != 0)
      flag_error($sformatf("%0d expected beats never came", filt_fifo.size()));
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

/* files.f */
rtl/bjef_pkg.sv
rtl/bytecode_jump_elision_filter.sv
sim/tb_top.sv
